### src/magnetometer_sample_correction_macros.svh
// Assertion macros used by the magnetometer sample correction top level
`ifndef MAGNETOMETER_SAMPLE_CORRECTION_MACROS_SVH
`define MAGNETOMETER_SAMPLE_CORRECTION_MACROS_SVH

// Same-cycle implication, sampled on clk, disabled while rst is high
`define MSC_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, disabled while rst is high
`define MSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/mscor_pkg.sv
// Types and constants for the magnetometer sample correction block
package mscor_pkg;

  localparam int RAW_W   = 16;
  localparam int FIELD_W = 24;
  localparam int SENS_W  = 20;  // sensitivity-corrected axis, 1/16 uT
  localparam int P1_W    = 25;  // raw * (asa + 128)
  localparam int P2_W    = 38;  // raw * (asa + 128) * 9824
  localparam int COEF_W  = 16;
  localparam int BIAS_W  = 16;
  localparam int PROD_W  = COEF_W + SENS_W;
  localparam int ACC_W   = PROD_W + 2;

  localparam int APB_ADDR_W = 6;
  localparam int APB_DATA_W = 64;

  localparam int SHIFT_16BIT = 20;
  localparam int SHIFT_14BIT = 18;

  localparam logic signed [14:0] FS_NUM     = 15'sd9824;
  localparam logic [8:0]         ASA_OFFSET = 9'd128;

  localparam logic signed [P2_W-1:0] HALF_16BIT = P2_W'(1) <<< (SHIFT_16BIT - 1);
  localparam logic signed [P2_W-1:0] HALF_14BIT = P2_W'(1) <<< (SHIFT_14BIT - 1);

  localparam logic signed [FIELD_W-1:0] OUT_MAX = 24'sh7FFFFF;
  localparam logic signed [FIELD_W-1:0] OUT_MIN = 24'sh800000;

  typedef enum logic [2:0] {
    REG_SIXTEEN_BIT  = 3'd0,
    REG_SENS_ADJUST  = 3'd1,
    REG_NAV_ENU      = 3'd2,
    REG_APPLY_CORR   = 3'd3,
    REG_SCALE_DIAG   = 3'd4,
    REG_MISALIGN_1ST = 3'd5,
    REG_MISALIGN_2ND = 3'd6,
    REG_BIAS_XYZ     = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic signed [RAW_W-1:0] raw_x;
    logic signed [RAW_W-1:0] raw_y;
    logic signed [RAW_W-1:0] raw_z;
  } sample_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] field_x;
    logic signed [FIELD_W-1:0] field_y;
    logic signed [FIELD_W-1:0] field_z;
  } field_t;

  typedef struct packed {
    logic signed [SENS_W-1:0] x;
    logic signed [SENS_W-1:0] y;
    logic signed [SENS_W-1:0] z;
  } sens_t;

  typedef struct packed {
    logic        sixteen_bit_output;
    logic [23:0] sens_adjust;
    logic        nav_enu;
    logic        apply_correction;
    logic [47:0] scale_diag;
    logic [47:0] misalign_first;
    logic [47:0] misalign_second;
    logic [47:0] bias_xyz;
  } cfg_t;

endpackage

### src/mscor_regs.sv
// APB configuration register file
module mscor_regs import mscor_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output cfg_t                  cfg
);

  reg_index_t index;
  logic       wr_en;

  assign index = reg_index_t'(paddr[APB_ADDR_W-1:3]);
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sixteen_bit_output <= 1'b1;
      cfg.sens_adjust        <= 24'h808080;
      cfg.nav_enu            <= 1'b0;
      cfg.apply_correction   <= 1'b0;
      cfg.scale_diag         <= 48'h4000_4000_4000;
      cfg.misalign_first     <= '0;
      cfg.misalign_second    <= '0;
      cfg.bias_xyz           <= '0;
    end else if (wr_en) begin
      case (index)
        REG_SIXTEEN_BIT:  cfg.sixteen_bit_output <= pwdata[0];
        REG_SENS_ADJUST:  cfg.sens_adjust        <= pwdata[23:0];
        REG_NAV_ENU:      cfg.nav_enu            <= pwdata[0];
        REG_APPLY_CORR:   cfg.apply_correction   <= pwdata[0];
        REG_SCALE_DIAG:   cfg.scale_diag         <= pwdata[47:0];
        REG_MISALIGN_1ST: cfg.misalign_first     <= pwdata[47:0];
        REG_MISALIGN_2ND: cfg.misalign_second    <= pwdata[47:0];
        REG_BIAS_XYZ:     cfg.bias_xyz           <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (index)
      REG_SIXTEEN_BIT:  prdata = APB_DATA_W'(cfg.sixteen_bit_output);
      REG_SENS_ADJUST:  prdata = APB_DATA_W'(cfg.sens_adjust);
      REG_NAV_ENU:      prdata = APB_DATA_W'(cfg.nav_enu);
      REG_APPLY_CORR:   prdata = APB_DATA_W'(cfg.apply_correction);
      REG_SCALE_DIAG:   prdata = APB_DATA_W'(cfg.scale_diag);
      REG_MISALIGN_1ST: prdata = APB_DATA_W'(cfg.misalign_first);
      REG_MISALIGN_2ND: prdata = APB_DATA_W'(cfg.misalign_second);
      REG_BIAS_XYZ:     prdata = APB_DATA_W'(cfg.bias_xyz);
      default:          prdata = '0;
    endcase
  end

endmodule

### src/mscor_scale.sv
// Sensitivity scaling pipeline: fuse adjust, full-scale multiply, rounding, axis map
module mscor_scale import mscor_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    up_valid,
  output logic    up_ready,
  input  sample_t up_word,
  output logic    dn_valid,
  input  logic    dn_ready,
  output sens_t   dn_word
);

  logic signed [RAW_W-1:0]  raw [3];
  logic [7:0]               asa [3];
  logic signed [P1_W:0]     mul1 [3];
  logic signed [P1_W-1:0]   prod1 [3];
  logic signed [P2_W+1:0]   mul2 [3];
  logic signed [P2_W-1:0]   prod2 [3];
  logic signed [P2_W-1:0]   rsum [3];
  logic signed [SENS_W-1:0] sval [3];
  logic                     v1, v2, v3;
  logic                     r1, r2, r3;

  assign r3       = !v3 || dn_ready;
  assign r2       = !v2 || r3;
  assign r1       = !v1 || r2;
  assign up_ready = r1;
  assign dn_valid = v3;

  assign raw[0] = up_word.raw_x;
  assign raw[1] = up_word.raw_y;
  assign raw[2] = up_word.raw_z;
  assign asa[0] = cfg.sens_adjust[23:16];
  assign asa[1] = cfg.sens_adjust[15:8];
  assign asa[2] = cfg.sens_adjust[7:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mul1[i] = raw[i] * $signed({1'b0, {1'b0, asa[i]} + ASA_OFFSET});
      mul2[i] = prod1[i] * FS_NUM;
      // ties away from zero: negative values take one less before the shift
      rsum[i] = prod2[i] + (cfg.sixteen_bit_output ? HALF_16BIT : HALF_14BIT)
                - P2_W'(prod2[i][P2_W-1]);
      if (cfg.sixteen_bit_output) begin
        sval[i] = SENS_W'(rsum[i] >>> SHIFT_16BIT);
      end else begin
        sval[i] = SENS_W'(rsum[i] >>> SHIFT_14BIT);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (r1) v1 <= up_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && up_valid) begin
      for (int i = 0; i < 3; i++) prod1[i] <= mul1[i][P1_W-1:0];
    end
    if (r2 && v1) begin
      for (int i = 0; i < 3; i++) prod2[i] <= mul2[i][P2_W-1:0];
    end
    if (r3 && v2) begin
      if (cfg.nav_enu) begin
        dn_word.x <= sval[1];
        dn_word.y <= sval[0];
        dn_word.z <= -sval[2];
      end else begin
        dn_word.x <= sval[0];
        dn_word.y <= sval[1];
        dn_word.z <= sval[2];
      end
    end
  end

endmodule

### src/mscor_matrix.sv
// Correction pipeline: optional 3x3 matrix, row sums, rounding, bias and saturation
module mscor_matrix import mscor_pkg::*; #(
  parameter int COEF_FRAC_BITS = 14
) (
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  input  logic   up_valid,
  output logic   up_ready,
  input  sens_t  up_word,
  output logic   dn_valid,
  input  logic   dn_ready,
  output field_t dn_word
);

  localparam int RND_W  = ACC_W - COEF_FRAC_BITS + 1;
  localparam int DIFF_W = RND_W + 1;
  localparam int EXT_W  = (DIFF_W > FIELD_W + 1) ? DIFF_W : FIELD_W + 1;
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);

  logic signed [COEF_W-1:0] coef [3][3];
  logic signed [BIAS_W-1:0] bias [3];
  logic signed [SENS_W-1:0] sin [3];
  logic signed [PROD_W-1:0] prod [3][3];
  logic signed [ACC_W-1:0]  acc [3];
  logic signed [ACC_W-1:0]  acc_rnd [3];
  logic signed [RND_W-1:0]  rnd [3];
  logic signed [DIFF_W-1:0] diff [3];
  logic signed [EXT_W-1:0]  diff_ext [3];
  logic signed [FIELD_W-1:0] sat [3];
  logic signed [FIELD_W-1:0] fout [3];
  sens_t                    pass4, pass5, pass6;
  logic                     v4, v5, v6, v7;
  logic                     r4, r5, r6, r7;

  assign r7       = !v7 || dn_ready;
  assign r6       = !v6 || r7;
  assign r5       = !v5 || r6;
  assign r4       = !v4 || r5;
  assign up_ready = r4;
  assign dn_valid = v7;

  assign sin[0] = up_word.x;
  assign sin[1] = up_word.y;
  assign sin[2] = up_word.z;

  always_comb begin
    coef[0][0] = cfg.scale_diag[47:32];
    coef[1][1] = cfg.scale_diag[31:16];
    coef[2][2] = cfg.scale_diag[15:0];
    coef[0][1] = cfg.misalign_first[47:32];
    coef[0][2] = cfg.misalign_first[31:16];
    coef[1][0] = cfg.misalign_first[15:0];
    coef[1][2] = cfg.misalign_second[47:32];
    coef[2][0] = cfg.misalign_second[31:16];
    coef[2][1] = cfg.misalign_second[15:0];
    bias[0]    = cfg.bias_xyz[47:32];
    bias[1]    = cfg.bias_xyz[31:16];
    bias[2]    = cfg.bias_xyz[15:0];
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc_rnd[i]  = acc[i] + RND_HALF - ACC_W'(acc[i][ACC_W-1]);
      diff[i]     = DIFF_W'(rnd[i]) - DIFF_W'(bias[i]);
      diff_ext[i] = EXT_W'(diff[i]);
      if (&diff_ext[i][EXT_W-1:FIELD_W-1] || !(|diff_ext[i][EXT_W-1:FIELD_W-1])) begin
        sat[i] = diff_ext[i][FIELD_W-1:0];
      end else if (diff_ext[i][EXT_W-1]) begin
        sat[i] = OUT_MIN;
      end else begin
        sat[i] = OUT_MAX;
      end
    end
    if (cfg.apply_correction) begin
      fout[0] = sat[0];
      fout[1] = sat[1];
      fout[2] = sat[2];
    end else begin
      fout[0] = FIELD_W'(pass6.x);
      fout[1] = FIELD_W'(pass6.y);
      fout[2] = FIELD_W'(pass6.z);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      if (r4) v4 <= up_valid;
      if (r5) v5 <= v4;
      if (r6) v6 <= v5;
      if (r7) v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (r4 && up_valid) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) prod[i][j] <= coef[i][j] * sin[j];
      end
      pass4 <= up_word;
    end
    if (r5 && v4) begin
      for (int i = 0; i < 3; i++) begin
        acc[i] <= ACC_W'(prod[i][0]) + ACC_W'(prod[i][1]) + ACC_W'(prod[i][2]);
      end
      pass5 <= pass4;
    end
    if (r6 && v5) begin
      for (int i = 0; i < 3; i++) rnd[i] <= RND_W'(acc_rnd[i] >>> COEF_FRAC_BITS);
      pass6 <= pass5;
    end
    if (r7 && v6) begin
      dn_word.field_x <= fout[0];
      dn_word.field_y <= fout[1];
      dn_word.field_z <= fout[2];
    end
  end

endmodule

### src/magnetometer_sample_correction.sv
// Magnetometer sample correction, top level
//
// Takes one signed 16-bit raw magnetometer triple per word and returns the
// field in 1/16 uT as three signed 24-bit saturated axes. One word can be
// taken every clock cycle while sample_ready is high; the datapath has seven
// register stages (three for sensitivity scaling, four for the matrix
// correction). Each stage holds its word when the next one is full, so a stall
// on the result side fills bubbles first and only then pushes back on
// sample_ready. Registers are written over the APB port at byte address
// 8*index and must only change while no word is in flight; they are read back
// with bits above each register's width as zero.
`include "magnetometer_sample_correction_macros.svh"

module magnetometer_sample_correction import mscor_pkg::*; #(
  parameter int COEF_FRAC_BITS = 14
) (
  input  logic                  clk,
  input  logic                  rst,
  // sample channel
  input  logic                  sample_valid,
  output logic                  sample_ready,
  input  sample_t               sample,
  // result channel
  output logic                  result_valid,
  input  logic                  result_ready,
  output field_t                result,
  // APB configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t  cfg;
  logic  mid_valid;
  logic  mid_ready;
  sens_t mid_word;

  // zero-wait-state register access
  assign pready = 1'b1;

  mscor_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // raw counts -> 1/16 uT with fuse sensitivity, optional NED to ENU remap
  mscor_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .up_valid (sample_valid),
    .up_ready (sample_ready),
    .up_word  (sample),
    .dn_valid (mid_valid),
    .dn_ready (mid_ready),
    .dn_word  (mid_word)
  );

  // optional scale/misalignment matrix and bias, then saturation to 24 bits
  mscor_matrix #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_matrix (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .up_valid (mid_valid),
    .up_ready (mid_ready),
    .up_word  (mid_word),
    .dn_valid (result_valid),
    .dn_ready (result_ready),
    .dn_word  (result)
  );

  // back-pressure on the sample side only ever comes from a blocked result
  `MSC_ASSERT_IMPLIES(a_stall_from_result, !sample_ready, result_valid && !result_ready, "sample_ready low without a blocked result")

  // a sensitivity write lands in the register on the following cycle
  `MSC_ASSERT_NEXT(a_sens_write, psel && penable && pwrite && (paddr[5:3] == REG_SENS_ADJUST), cfg.sens_adjust == $past(pwdata[23:0]), "sens_adjust write not taken")

endmodule

### verif/magnetometer_sample_correction_test.sv
// Testbench for the magnetometer sample correction block, with field predictor and checker
`timescale 1ns / 1ps

import mscor_pkg::*;

// Predicts the corrected field for each accepted sample and checks results in order
class correction_tracker;
  cfg_t   settings;
  field_t pending_fields[$];
  int     mismatches;

  function new();
    settings.sixteen_bit_output = 1'b1;
    settings.sens_adjust        = 24'h808080;
    settings.nav_enu            = 1'b0;
    settings.apply_correction   = 1'b0;
    settings.scale_diag         = 48'h4000_4000_4000;
    settings.misalign_first     = '0;
    settings.misalign_second    = '0;
    settings.bias_xyz           = '0;
    mismatches = 0;
  endfunction

  task report(string what);
    if (mismatches < 100) $display("MISMATCH @%0t: %s", $realtime, what);
    mismatches++;
  endtask

  // Mirror of a register write; bits above the register width are dropped
  function void write_reg(reg_index_t idx, logic [63:0] value);
    case (idx)
      REG_SIXTEEN_BIT:  settings.sixteen_bit_output = value[0];
      REG_SENS_ADJUST:  settings.sens_adjust        = value[23:0];
      REG_NAV_ENU:      settings.nav_enu            = value[0];
      REG_APPLY_CORR:   settings.apply_correction   = value[0];
      REG_SCALE_DIAG:   settings.scale_diag         = value[47:0];
      REG_MISALIGN_1ST: settings.misalign_first     = value[47:0];
      REG_MISALIGN_2ND: settings.misalign_second    = value[47:0];
      REG_BIAS_XYZ:     settings.bias_xyz           = value[47:0];
      default: ;
    endcase
  endfunction

  // Divide by 2^sh, nearest, ties away from zero
  function longint round_half_away(longint v, int unsigned sh);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (longint'(1) <<< (sh - 1))) >>> sh;
    return (v < 0) ? -m : m;
  endfunction

  // Lane k of a packed triple, k = 0 is the top lane
  function longint lane16(logic [47:0] w, int k);
    return longint'($signed(w[47 - 16*k -: 16]));
  endfunction

  function longint clamp24(longint v);
    if (v > longint'(OUT_MAX)) return longint'(OUT_MAX);
    if (v < longint'(OUT_MIN)) return longint'(OUT_MIN);
    return v;
  endfunction

  function field_t corrected_field(sample_t s);
    longint      raw [3];
    longint      sens [3];
    longint      res [3];
    longint      coef [3][3];
    longint      acc;
    longint      swap;
    logic [7:0]  asa;
    int unsigned shift;
    field_t      f;
    raw[0] = longint'($signed(s.raw_x));
    raw[1] = longint'($signed(s.raw_y));
    raw[2] = longint'($signed(s.raw_z));
    shift = settings.sixteen_bit_output ? SHIFT_16BIT : SHIFT_14BIT;
    for (int i = 0; i < 3; i++) begin
      asa = settings.sens_adjust[23 - 8*i -: 8];
      sens[i] = round_half_away(raw[i] * longint'(FS_NUM) *
                                (longint'(asa) + longint'(ASA_OFFSET)), shift);
    end
    if (settings.nav_enu) begin
      swap    = sens[0];
      sens[0] = sens[1];
      sens[1] = swap;
      sens[2] = -sens[2];
    end
    if (settings.apply_correction) begin
      coef[0][0] = lane16(settings.scale_diag, 0);
      coef[1][1] = lane16(settings.scale_diag, 1);
      coef[2][2] = lane16(settings.scale_diag, 2);
      coef[0][1] = lane16(settings.misalign_first, 0);
      coef[0][2] = lane16(settings.misalign_first, 1);
      coef[1][0] = lane16(settings.misalign_first, 2);
      coef[1][2] = lane16(settings.misalign_second, 0);
      coef[2][0] = lane16(settings.misalign_second, 1);
      coef[2][1] = lane16(settings.misalign_second, 2);
      for (int i = 0; i < 3; i++) begin
        acc = 0;
        for (int j = 0; j < 3; j++) acc += coef[i][j] * sens[j];
        res[i] = round_half_away(acc, 14) - lane16(settings.bias_xyz, i);
      end
    end else begin
      for (int i = 0; i < 3; i++) res[i] = sens[i];
    end
    for (int i = 0; i < 3; i++) res[i] = clamp24(res[i]);
    f.field_x = res[0][FIELD_W-1:0];
    f.field_y = res[1][FIELD_W-1:0];
    f.field_z = res[2][FIELD_W-1:0];
    return f;
  endfunction

  function void note_sample(sample_t s);
    pending_fields.push_back(corrected_field(s));
  endfunction

  task check_field(field_t got);
    field_t want;
    if (pending_fields.size() == 0) begin
      report($sformatf("unexpected result %0d %0d %0d",
                       got.field_x, got.field_y, got.field_z));
    end else begin
      want = pending_fields.pop_front();
      if (got.field_x !== want.field_x)
        report($sformatf("field_x got %0d want %0d", got.field_x, want.field_x));
      if (got.field_y !== want.field_y)
        report($sformatf("field_y got %0d want %0d", got.field_y, want.field_y));
      if (got.field_z !== want.field_z)
        report($sformatf("field_z got %0d want %0d", got.field_z, want.field_z));
    end
  endtask
endclass

module magnetometer_sample_correction_test;

  localparam int FRAC_BITS     = 14;
  localparam int LATENCY       = 7;       // acceptance to result, through the block's register stages
  localparam int CYCLE_LIMIT   = 300000;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_WORDS   = 60;
  localparam int HOLD_CYCLES   = 200;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  sample_valid = 1'b0;
  logic                  sample_ready;
  sample_t               sample = '0;
  logic                  result_valid;
  logic                  result_ready = 1'b0;
  field_t                result;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  correction_tracker tracker;
  int                cycle_count = 0;
  bit                hold_wanted = 1'b0;   // asks the receiver for its long hold-off
  bit                hold_done = 1'b0;

  magnetometer_sample_correction #(.COEF_FRAC_BITS(FRAC_BITS)) u_top (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Run guard: a hang anywhere ends here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("magnetometer_sample_correction_test failed");
      $finish;
    end
  end

  // Result monitor: every accepted word is checked against the oldest prediction
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) tracker.check_field(result);
  end

  // Receiver: ready stretches, random stalls, short blocks, and one long hold-off
  // once the stimulus asks for it, so the pipe fills and pushes back on the sender
  initial begin
    int mode;
    int span;
    @(negedge rst);
    forever begin
      if (hold_wanted && !hold_done) begin
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        mode = $urandom_range(0, 2);
        span = $urandom_range(1, 30);
        for (int c = 0; c < span; c++) begin
          case (mode)
            0:       result_ready <= 1'b1;
            1:       result_ready <= $urandom_range(0, 1);
            default: result_ready <= (c >= 6);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // Two-phase APB write; the bus is left idle after each access
  task automatic apb_write(reg_index_t idx, logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.write_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one word and hold it until taken; valid is left high for the caller
  task automatic offer_word(sample_t s);
    sample_valid <= 1'b1;
    sample       <= s;
    do @(posedge clk); while (!sample_ready);
    tracker.note_sample(s);
  endtask

  // Sends words in bursts of random length with random gaps between them
  task automatic send_words(sample_t words[$]);
    int burst;
    int gap;
    burst = $urandom_range(1, 16);
    foreach (words[n]) begin
      offer_word(words[n]);
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 16);
        gap   = $urandom_range(0, 5);
        if (gap > 0) begin
          sample_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    sample_valid <= 1'b0;
  endtask

  // Waits for every outstanding word, then lets the pipe settle
  task automatic drain();
    int waited;
    waited = 0;
    while (tracker.pending_fields.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (tracker.pending_fields.size() != 0) begin
      tracker.report($sformatf("%0d results never arrived",
                               tracker.pending_fields.size()));
      tracker.pending_fields.delete();
    end
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_axis();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return 16'($urandom);
    if (pick < 85) begin
      case ($urandom_range(0, 4))
        0:       return 16'h7FFF;
        1:       return 16'h8000;
        2:       return 16'h0000;
        3:       return 16'hFFFF;
        default: return 16'h0001;
      endcase
    end
    return 16'($urandom_range(0, 64) - 32);
  endfunction

  function automatic sample_t random_word();
    sample_t s;
    s.raw_x = pick_axis();
    s.raw_y = pick_axis();
    s.raw_z = pick_axis();
    return s;
  endfunction

  // Extremes per axis, sign mixes and alternating bit patterns
  function automatic void directed_words(ref sample_t words[$]);
    words.delete();
    words.push_back({16'h7FFF, 16'h7FFF, 16'h7FFF});
    words.push_back({16'h8000, 16'h8000, 16'h8000});
    words.push_back({16'h0000, 16'h0000, 16'h0000});
    words.push_back({16'hFFFF, 16'h0001, 16'hFFFF});
    words.push_back({16'h0001, 16'hFFFF, 16'h0001});
    words.push_back({16'h7FFF, 16'h8000, 16'h0000});
    words.push_back({16'h8000, 16'h0000, 16'h7FFF});
    words.push_back({16'h5555, 16'hAAAA, 16'h5555});
  endfunction

  // Every register gets fresh random contents, upper bus bits included
  task automatic scramble_settings();
    apb_write(REG_SIXTEEN_BIT,  {$urandom, $urandom});
    apb_write(REG_SENS_ADJUST,  {$urandom, $urandom});
    apb_write(REG_NAV_ENU,      {$urandom, $urandom});
    apb_write(REG_APPLY_CORR,   {$urandom, $urandom});
    apb_write(REG_SCALE_DIAG,   {$urandom, $urandom});
    apb_write(REG_MISALIGN_1ST, {$urandom, $urandom});
    apb_write(REG_MISALIGN_2ND, {$urandom, $urandom});
    apb_write(REG_BIAS_XYZ,     {$urandom, $urandom});
  endtask

  initial begin
    sample_t words[$];
    tracker = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: 16-bit scale, unity fuse trim, no remap, no correction
    directed_words(words);
    send_words(words);
    drain();

    // Top extremes: 14-bit scale, largest trim, ENU, largest coefficients,
    // most negative bias; junk above each register's width must be dropped
    apb_write(REG_SIXTEEN_BIT,  64'hFFFF_FFFF_FFFF_FFFE);
    apb_write(REG_SENS_ADJUST,  64'hA5A5_A5A5_A5FF_FFFF);
    apb_write(REG_NAV_ENU,      64'h8000_0000_0000_0001);
    apb_write(REG_APPLY_CORR,   64'h0000_0001_0000_0001);
    apb_write(REG_SCALE_DIAG,   64'hFFFF_7FFF_7FFF_7FFF);
    apb_write(REG_MISALIGN_1ST, 64'h1234_7FFF_7FFF_7FFF);
    apb_write(REG_MISALIGN_2ND, 64'h0000_7FFF_7FFF_7FFF);
    apb_write(REG_BIAS_XYZ,     64'hFFFF_8000_8000_8000);
    directed_words(words);
    send_words(words);
    drain();

    // Bottom extremes: zero trim, most negative coefficients, largest bias
    apb_write(REG_SIXTEEN_BIT,  64'h0000_0000_0000_0001);
    apb_write(REG_SENS_ADJUST,  64'hFFFF_FFFF_FF00_0000);
    apb_write(REG_NAV_ENU,      64'h0000_0000_0000_0000);
    apb_write(REG_SCALE_DIAG,   64'h0000_8000_8000_8000);
    apb_write(REG_MISALIGN_1ST, 64'h0000_8000_8000_8000);
    apb_write(REG_MISALIGN_2ND, 64'hFFFF_8000_8000_8000);
    apb_write(REG_BIAS_XYZ,     64'h0000_7FFF_7FFF_7FFF);
    directed_words(words);
    send_words(words);
    drain();

    // Random settings per phase, random words; long receiver hold in the first
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      scramble_settings();
      if (p == 0) hold_wanted = 1'b1;
      words.delete();
      for (int n = 0; n < PHASE_WORDS; n++) words.push_back(random_word());
      send_words(words);
      drain();
    end

    if (tracker.mismatches == 0) begin
      $display("magnetometer_sample_correction_test passed");
    end else begin
      $display("magnetometer_sample_correction_test failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/mscor_pkg.sv
src/mscor_regs.sv
src/mscor_scale.sv
src/mscor_matrix.sv
src/magnetometer_sample_correction.sv
verif/magnetometer_sample_correction_test.sv
